@@ design/ell_pkg.sv @@
package ell_pkg;

  // default widths of the position and length counters
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF   = 8;

  // entries in the token queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // fixed payload widths
  localparam int unsigned CH_W   = 8;
  localparam int unsigned KIND_W = 5;
  localparam int unsigned ERR_W  = 2;

  // token kinds
  localparam logic [KIND_W-1:0] K_EOF    = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd1;
  localparam logic [KIND_W-1:0] K_NUMBER = 5'd2;
  localparam logic [KIND_W-1:0] K_LPAREN = 5'd3;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd4;
  localparam logic [KIND_W-1:0] K_LBRACE = 5'd5;
  localparam logic [KIND_W-1:0] K_RBRACE = 5'd6;
  localparam logic [KIND_W-1:0] K_ASSIGN = 5'd7;
  localparam logic [KIND_W-1:0] K_EQ     = 5'd8;
  localparam logic [KIND_W-1:0] K_NE     = 5'd9;
  localparam logic [KIND_W-1:0] K_NOT    = 5'd10;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd11;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd12;
  localparam logic [KIND_W-1:0] K_SLASH  = 5'd13;
  localparam logic [KIND_W-1:0] K_STAR   = 5'd14;
  localparam logic [KIND_W-1:0] K_CARET  = 5'd15;
  localparam logic [KIND_W-1:0] K_LT     = 5'd16;
  localparam logic [KIND_W-1:0] K_LE     = 5'd17;
  localparam logic [KIND_W-1:0] K_GT     = 5'd18;
  localparam logic [KIND_W-1:0] K_GE     = 5'd19;
  localparam logic [KIND_W-1:0] K_PRIME  = 5'd20;
  localparam logic [KIND_W-1:0] K_COMMA  = 5'd21;
  localparam logic [KIND_W-1:0] K_ERROR  = 5'd22;

  // error codes
  localparam logic [ERR_W-1:0] E_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] E_LINE_END = 2'd1;
  localparam logic [ERR_W-1:0] E_POINTS   = 2'd2;
  localparam logic [ERR_W-1:0] E_UNEXP    = 2'd3;

  // source characters
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_FF_END = 8'hFF;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CH_W-1:0] CH_FEED   = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CH_W-1:0] CH_PRIME  = 8'h27;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_0      = 8'h30;
  localparam logic [CH_W-1:0] CH_9      = 8'h39;
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CH_W-1:0] CH_USCORE = 8'h5F;
  localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_end(input logic [CH_W-1:0] c);
    return (c == CH_NUL) || (c == CH_FF_END);
  endfunction

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FEED);
  endfunction

  // kind of a one-byte token, K_ERROR when the byte is not one
  function automatic logic [KIND_W-1:0] single_kind(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_SLASH:  k = K_SLASH;
      CH_STAR:   k = K_STAR;
      CH_CARET:  k = K_CARET;
      CH_PRIME:  k = K_PRIME;
      CH_COMMA:  k = K_COMMA;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

@@ design/ell_if.sv @@
interface ell_in_if import ell_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface ell_out_if import ell_pkg::*; #(
  parameter int unsigned PosW = POSITION_BITS_DEF,
  parameter int unsigned LenW = LENGTH_BITS_DEF
) ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [ERR_W-1:0]  error_code;
  logic [PosW-1:0]   line_number;
  logic [PosW-1:0]   start_column;
  logic [LenW-1:0]   token_length;
  logic              last;

  modport source (output valid, output token_kind, output error_code, output line_number,
                  output start_column, output token_length, output last, input ready);
  modport sink (input valid, input token_kind, input error_code, input line_number,
                input start_column, input token_length, input last, output ready);
endinterface

@@ design/ell_front.sv @@
module ell_front import ell_pkg::*; #(
  parameter int unsigned PosW = POSITION_BITS_DEF,
  parameter int unsigned LenW = LENGTH_BITS_DEF,
  localparam int unsigned TokW = KIND_W + ERR_W + 2 * PosW + LenW,
  localparam int unsigned EntW = 1 + 2 * TokW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ell_in_if.sink          in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output logic [EntW-1:0] entry_o
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_NUMBER  = 4'd1;
  localparam logic [3:0] M_IDENT   = 4'd2;
  localparam logic [3:0] M_EQ      = 4'd3;
  localparam logic [3:0] M_BANG    = 4'd4;
  localparam logic [3:0] M_LT      = 4'd5;
  localparam logic [3:0] M_GT      = 4'd6;
  localparam logic [3:0] M_CR      = 4'd7;
  localparam logic [3:0] M_COMMENT = 4'd8;
  localparam logic [3:0] M_DONE    = 4'd9;

  localparam logic [PosW-1:0] POS_ONE = PosW'(1);
  localparam logic [LenW-1:0] LEN_ONE = LenW'(1);
  localparam logic [LenW-1:0] LEN_TWO = LenW'(2);

  logic [3:0]      mode_q, mode_d;
  logic [PosW-1:0] line_q, line_d;
  logic [PosW-1:0] col_q, col_d;
  logic [PosW-1:0] tsc_q, tsc_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [1:0]      pts_q, pts_d;

  logic            accept;
  logic [CH_W-1:0] c;
  logic [PosW-1:0] col_inc, line_inc;
  logic [LenW-1:0] cnt_inc;
  logic            go_idle;

  // token closed by the pending mode and token formed by the byte itself
  logic              em_a, em_b;
  logic [KIND_W-1:0] kind_a, kind_b;
  logic [ERR_W-1:0]  err_a, err_b;
  logic [LenW-1:0]   len_a, len_b;
  logic [TokW-1:0]   tok_a, tok_b;

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & ~q_full_i;
  assign c          = in_i.ch;

  assign col_inc  = (&col_q) ? col_q : col_q + POS_ONE;
  assign line_inc = (&line_q) ? line_q : line_q + POS_ONE;
  assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + LEN_ONE;

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    tsc_d   = tsc_q;
    cnt_d   = cnt_q;
    pts_d   = pts_q;
    go_idle = 1'b1;
    em_a    = 1'b0;
    kind_a  = K_EOF;
    err_a   = E_NONE;
    len_a   = '0;
    em_b    = 1'b0;
    kind_b  = K_EOF;
    err_b   = E_NONE;
    len_b   = '0;

    // close or extend the pending token
    unique case (mode_q)
      M_IDLE: begin
      end
      M_DONE: begin
        em_a    = 1'b1;
        go_idle = 1'b0;
      end
      M_NUMBER: begin
        if (is_digit(c) || c == CH_DOT) begin
          if (c == CH_DOT) pts_d = (pts_q >= 2'd2) ? 2'd2 : pts_q + 2'd1;
          cnt_d   = cnt_inc;
          col_d   = col_inc;
          go_idle = 1'b0;
        end else begin
          em_a   = 1'b1;
          kind_a = (pts_q > 2'd1) ? K_ERROR : K_NUMBER;
          err_a  = (pts_q > 2'd1) ? E_POINTS : E_NONE;
          len_a  = cnt_q;
        end
      end
      M_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == CH_USCORE) begin
          cnt_d   = cnt_inc;
          col_d   = col_inc;
          go_idle = 1'b0;
        end else begin
          em_a   = 1'b1;
          kind_a = K_IDENT;
          len_a  = cnt_q;
        end
      end
      M_EQ, M_BANG, M_LT, M_GT: begin
        em_a = 1'b1;
        if (c == CH_EQ) begin
          unique case (mode_q)
            M_EQ:    kind_a = K_EQ;
            M_BANG:  kind_a = K_NE;
            M_LT:    kind_a = K_LE;
            default: kind_a = K_GE;
          endcase
          len_a   = LEN_TWO;
          col_d   = col_inc;
          mode_d  = M_IDLE;
          go_idle = 1'b0;
        end else begin
          unique case (mode_q)
            M_EQ:    kind_a = K_ASSIGN;
            M_BANG:  kind_a = K_NOT;
            M_LT:    kind_a = K_LT;
            default: kind_a = K_GT;
          endcase
          len_a = LEN_ONE;
        end
      end
      M_CR: begin
        if (c == CH_LF) begin
          line_d  = line_inc;
          col_d   = POS_ONE;
          mode_d  = M_IDLE;
          go_idle = 1'b0;
        end else begin
          em_a   = 1'b1;
          kind_a = K_ERROR;
          err_a  = E_LINE_END;
        end
      end
      M_COMMENT: begin
        if (!is_end(c) && c != CH_LF) begin
          col_d   = col_inc;
          go_idle = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // lex the byte from idle
    if (go_idle) begin
      mode_d = M_IDLE;
      priority if (is_end(c)) begin
        tsc_d  = col_q;
        em_b   = 1'b1;
        mode_d = M_DONE;
      end else if (is_blank(c)) begin
        col_d = col_inc;
      end else if (c == CH_LF) begin
        line_d = line_inc;
        col_d  = POS_ONE;
      end else if (c == CH_CR) begin
        tsc_d  = col_q;
        mode_d = M_CR;
        col_d  = col_inc;
      end else if (c == CH_COLON) begin
        mode_d = M_COMMENT;
        col_d  = col_inc;
      end else if (is_digit(c) || c == CH_DOT) begin
        pts_d  = (c == CH_DOT) ? 2'd1 : 2'd0;
        mode_d = M_NUMBER;
        tsc_d  = col_q;
        cnt_d  = LEN_ONE;
        col_d  = col_inc;
      end else if (is_letter(c) || c == CH_USCORE || c == CH_EQ || c == CH_BANG
                   || c == CH_LT || c == CH_GT) begin
        priority if (c == CH_EQ) mode_d = M_EQ;
        else if (c == CH_BANG) mode_d = M_BANG;
        else if (c == CH_LT) mode_d = M_LT;
        else if (c == CH_GT) mode_d = M_GT;
        else mode_d = M_IDENT;
        tsc_d = col_q;
        cnt_d = LEN_ONE;
        col_d = col_inc;
      end else begin
        em_b   = 1'b1;
        kind_b = single_kind(c);
        err_b  = (single_kind(c) == K_ERROR) ? E_UNEXP : E_NONE;
        len_b  = LEN_ONE;
        col_d  = col_inc;
      end
    end
  end

  assign tok_a = {kind_a, err_a, line_q, tsc_q, len_a};
  assign tok_b = {kind_b, err_b, line_q, col_q, len_b};

  assign push_o  = accept & (em_a | em_b);
  assign entry_o = em_a ? {em_b, tok_b, tok_a} : {1'b0, tok_b, tok_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      line_q <= POS_ONE;
      col_q  <= POS_ONE;
      tsc_q  <= '0;
      cnt_q  <= '0;
      pts_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      tsc_q  <= tsc_d;
      cnt_q  <= cnt_d;
      pts_q  <= pts_d;
    end
  end

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_q == M_DONE) |=> (mode_q == M_DONE))
    else $error("end of input state left");

  a_done_single_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_q == M_DONE) |-> (push_o && !entry_o[EntW-1]
      && entry_o[TokW-1 -: KIND_W] == K_EOF))
    else $error("after end of input a byte did not give one eof token");

  a_error_code_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> ((entry_o[TokW-1 -: KIND_W] == K_ERROR)
      == (entry_o[TokW-KIND_W-1 -: ERR_W] != E_NONE)))
    else $error("error code does not match token kind");

endmodule

@@ design/ell_queue.sv @@
module ell_queue import ell_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned Depth = QUEUE_DEPTH,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0]    mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(Depth)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with fill count");

endmodule

@@ design/ell_back.sv @@
module ell_back import ell_pkg::*; #(
  parameter int unsigned PosW = POSITION_BITS_DEF,
  parameter int unsigned LenW = LENGTH_BITS_DEF,
  localparam int unsigned TokW = KIND_W + ERR_W + 2 * PosW + LenW,
  localparam int unsigned EntW = 1 + 2 * TokW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  logic [EntW-1:0] q_data_i,
  output logic            q_pop_o,
  ell_out_if.source       out_o
);

  logic [EntW-1:0] hold_q;
  logic            valid_q;
  logic            phase_q;
  logic            two;
  logic            take, finish, step;
  logic [TokW-1:0] tok;

  assign two    = hold_q[EntW-1];
  assign take   = valid_q & out_o.ready;
  assign finish = take & (phase_q | ~two);
  assign step   = take & ~phase_q & two;
  assign q_pop_o = q_valid_i & (~valid_q | finish);

  assign tok = phase_q ? hold_q[2*TokW-1:TokW] : hold_q[TokW-1:0];

  assign out_o.valid        = valid_q;
  assign out_o.token_kind   = tok[TokW-1 -: KIND_W];
  assign out_o.error_code   = tok[TokW-KIND_W-1 -: ERR_W];
  assign out_o.line_number  = tok[LenW+2*PosW-1 -: PosW];
  assign out_o.start_column = tok[LenW+PosW-1 -: PosW];
  assign out_o.token_length = tok[LenW-1:0];
  assign out_o.last         = phase_q | ~two;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) hold_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      phase_q <= 1'b0;
    end else if (step) begin
      phase_q <= 1'b1;
    end else if (finish) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end
  end

  a_second_only_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (valid_q && two))
    else $error("second token shown for a single-token entry");

endmodule

@@ design/expression_language_lexer.sv @@
// channel  dir  payload                                           transaction
// in_i     in   ch                                                one source byte
// out_o    out  token_kind error_code line_number start_column    one token
//               token_length last
//
// a byte is taken every cycle while the token queue has room; the front
// classifies it and updates the line, column and pending-token registers
// a byte that closes one token and forms a one-byte token yields two tokens,
// which the back hands out in turn; output drain sets the rate at such bytes
// tokens pass the queue and back register; reset returns to line 1 col 1
// output stalls fill the queue, and in_i.ready drops only when it is full
module expression_language_lexer import ell_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ell_in_if.sink    in_i,
  ell_out_if.source out_o
);

  // one queue entry: a flag for two tokens, then two packed tokens
  localparam int unsigned TokW = KIND_W + ERR_W + 2 * POSITION_BITS + LENGTH_BITS;
  localparam int unsigned EntW = 1 + 2 * TokW;

  logic            push, q_full, q_valid, q_pop;
  logic [EntW-1:0] push_data, q_data;

  // front: byte classification and lexer state
  ell_front #(
    .PosW (POSITION_BITS),
    .LenW (LENGTH_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_data)
  );

  // short queue so input and output stall apart
  ell_queue #(
    .W     (EntW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // back: output register, splits a token pair into two transactions
  ell_back #(
    .PosW (POSITION_BITS),
    .LenW (LENGTH_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

@@ tb/sv/tb_expression_language_lexer.sv @@
`timescale 1ns / 1ps

module tb_expression_language_lexer;
  import ell_pkg::*;

  // counter widths as built
  localparam int unsigned POS_W = POSITION_BITS_DEF;
  localparam int unsigned LEN_W = LENGTH_BITS_DEF;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // run limits in clock cycles and test sizes in bytes
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_LIMIT   = 2_000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RANDOM_BYTES  = 480;
  localparam int unsigned BURST_BYTES   = 200;
  localparam int unsigned HOLD_CYCLES   = 150;

  // one-byte operators the random text draws from
  localparam logic [CH_W-1:0] OP_BYTES [15] = '{
    CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_PLUS, CH_MINUS, CH_SLASH,
    CH_STAR, CH_CARET, CH_PRIME, CH_COMMA, CH_EQ, CH_BANG, CH_LT, CH_GT
  };

  // scanner modes of the predictor
  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_EQ, SCAN_BANG, SCAN_LT, SCAN_GT,
    SCAN_CR, SCAN_COMMENT, SCAN_DONE
  } scan_mode_e;

  // one token as seen on the output channel
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  col;
    logic [LEN_W-1:0]  len;
    logic              last;
  } token_t;

  logic clk_i;
  logic rst_ni;

  ell_in_if in_if ();
  ell_out_if #(.PosW(POS_W), .LenW(LEN_W)) out_if ();

  expression_language_lexer #(
    .POSITION_BITS(POS_W),
    .LENGTH_BITS  (LEN_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state, mirrors the scanner after every accepted byte
  scan_mode_e       scan_mode;
  logic [POS_W-1:0] line_ctr;
  logic [POS_W-1:0] col_ctr;
  logic [POS_W-1:0] tok_col;
  logic [LEN_W-1:0] tok_len;
  logic [1:0]       point_ctr;

  // tokens predicted but not yet seen, oldest first
  token_t tokens_due[$];

  // idle rates in percent and the receiver hold-off request
  int unsigned source_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_request;

  // bookkeeping
  int unsigned mismatches;
  int unsigned tokens_checked;
  int unsigned bytes_sent;
  int unsigned comment_bytes;
  int unsigned input_stall_cycles;
  int unsigned cycle_count;

  string odd_chars = "#$%&;?@[]|~\"\\";

  // free-running clock, 2 ns period
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
                 tokens_due.size());
        $display("expression_language_lexer verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic logic is_num_char(logic [CH_W-1:0] c);
    return (c >= CH_0 && c <= CH_9) || c == CH_DOT;
  endfunction

  // identifier body: letters, digits, underscore
  function automatic logic is_word_char(logic [CH_W-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_0 && c <= CH_9) || c == CH_USCORE;
  endfunction

  function automatic token_t make_token(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err,
                                        logic [POS_W-1:0] col, logic [LEN_W-1:0] len);
    token_t t;
    t.kind = kind;
    t.err  = err;
    t.line = line_ctr;
    t.col  = col;
    t.len  = len;
    t.last = 1'b0;
    return t;
  endfunction

  // column and line stop at their top value
  function automatic void step_column();
    if (col_ctr != POS_MAX) col_ctr = col_ctr + 1'b1;
  endfunction

  function automatic void step_line();
    if (line_ctr != POS_MAX) line_ctr = line_ctr + 1'b1;
    col_ctr = 1;
  endfunction

  function automatic void open_token(scan_mode_e m);
    scan_mode = m;
    tok_col   = col_ctr;
    tok_len   = 1;
    step_column();
  endfunction

  function automatic void reset_scanner();
    scan_mode = SCAN_IDLE;
    line_ctr  = 1;
    col_ctr   = 1;
    tok_col   = 0;
    tok_len   = 0;
    point_ctr = 0;
  endfunction

  // lex one accepted byte and queue the tokens it closes or forms
  function automatic void scan_byte(logic [CH_W-1:0] c);
    token_t            toks[$];
    logic              go_idle;
    logic              op_open;
    logic [KIND_W-1:0] one_kind;
    logic [KIND_W-1:0] two_kind;
    logic [KIND_W-1:0] lone_kind;
    go_idle   = 1'b1;
    op_open   = 1'b0;
    one_kind  = K_EOF;
    two_kind  = K_EOF;
    lone_kind = K_EOF;

    // first close or extend whatever token is pending
    case (scan_mode)
      SCAN_DONE: begin
        // after end of input every byte repeats the eof token
        toks.push_back(make_token(K_EOF, E_NONE, tok_col, 0));
        go_idle = 1'b0;
      end
      SCAN_NUMBER: begin
        if (is_num_char(c)) begin
          if (c == CH_DOT && point_ctr != 2'd2) point_ctr = point_ctr + 1'b1;
          if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
          step_column();
          go_idle = 1'b0;
        end else if (point_ctr > 2'd1) begin
          toks.push_back(make_token(K_ERROR, E_POINTS, tok_col, tok_len));
        end else begin
          toks.push_back(make_token(K_NUMBER, E_NONE, tok_col, tok_len));
        end
      end
      SCAN_IDENT: begin
        if (is_word_char(c)) begin
          if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
          step_column();
          go_idle = 1'b0;
        end else begin
          toks.push_back(make_token(K_IDENT, E_NONE, tok_col, tok_len));
        end
      end
      SCAN_EQ: begin
        op_open = 1'b1; one_kind = K_ASSIGN; two_kind = K_EQ;
      end
      SCAN_BANG: begin
        op_open = 1'b1; one_kind = K_NOT; two_kind = K_NE;
      end
      SCAN_LT: begin
        op_open = 1'b1; one_kind = K_LT; two_kind = K_LE;
      end
      SCAN_GT: begin
        op_open = 1'b1; one_kind = K_GT; two_kind = K_GE;
      end
      SCAN_CR: begin
        if (c == CH_LF) begin
          step_line();
          scan_mode = SCAN_IDLE;
          go_idle   = 1'b0;
        end else begin
          // lone carriage return, zero-length error at its column
          toks.push_back(make_token(K_ERROR, E_LINE_END, tok_col, 0));
        end
      end
      SCAN_COMMENT: begin
        if (c != CH_NUL && c != CH_FF_END && c != CH_LF) begin
          step_column();
          go_idle = 1'b0;
        end
      end
      default: ;
    endcase

    // pending operator: two-byte form on '=', else the one-byte form
    if (op_open) begin
      if (c == CH_EQ) begin
        toks.push_back(make_token(two_kind, E_NONE, tok_col, 2));
        step_column();
        scan_mode = SCAN_IDLE;
        go_idle   = 1'b0;
      end else begin
        toks.push_back(make_token(one_kind, E_NONE, tok_col, 1));
      end
    end

    // then lex the byte itself from idle
    if (go_idle) begin
      scan_mode = SCAN_IDLE;
      if (c == CH_NUL || c == CH_FF_END) begin
        tok_col = col_ctr;
        toks.push_back(make_token(K_EOF, E_NONE, col_ctr, 0));
        scan_mode = SCAN_DONE;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FEED) begin
        step_column();
      end else if (c == CH_LF) begin
        step_line();
      end else if (c == CH_CR) begin
        tok_col   = col_ctr;
        scan_mode = SCAN_CR;
        step_column();
      end else if (c == CH_COLON) begin
        scan_mode = SCAN_COMMENT;
        step_column();
      end else if (is_num_char(c)) begin
        point_ctr = (c == CH_DOT) ? 2'd1 : 2'd0;
        open_token(SCAN_NUMBER);
      end else if (is_word_char(c)) begin
        open_token(SCAN_IDENT);
      end else begin
        case (c)
          CH_EQ:     open_token(SCAN_EQ);
          CH_BANG:   open_token(SCAN_BANG);
          CH_LT:     open_token(SCAN_LT);
          CH_GT:     open_token(SCAN_GT);
          CH_LPAREN: lone_kind = K_LPAREN;
          CH_RPAREN: lone_kind = K_RPAREN;
          CH_LBRACE: lone_kind = K_LBRACE;
          CH_RBRACE: lone_kind = K_RBRACE;
          CH_PLUS:   lone_kind = K_PLUS;
          CH_MINUS:  lone_kind = K_MINUS;
          CH_SLASH:  lone_kind = K_SLASH;
          CH_STAR:   lone_kind = K_STAR;
          CH_CARET:  lone_kind = K_CARET;
          CH_PRIME:  lone_kind = K_PRIME;
          CH_COMMA:  lone_kind = K_COMMA;
          default:   lone_kind = K_ERROR;
        endcase
        if (lone_kind != K_EOF) begin
          toks.push_back(make_token(lone_kind, (lone_kind == K_ERROR) ? E_UNEXP : E_NONE,
                                    col_ctr, 1));
          step_column();
        end
      end
    end

    // the final token of this byte carries last
    if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
    foreach (toks[i]) tokens_due.push_back(toks[i]);
  endfunction

  // ---------------------------------------------------------------------
  // receiver: random ready, plus a long hold-off on request
  // ---------------------------------------------------------------------

  initial begin
    int unsigned hold_left;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        // hold ready low for a counted stretch so the token queue fills
        out_if.ready <= 1'b0;
        hold_left    = hold_request;
        hold_request = 0;
        while (hold_left > 1) begin
          @(posedge clk_i);
          hold_left--;
        end
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // checker: every output transaction against the oldest prediction
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at cycle %0d, token %0d: %s got %0d want %0d", cycle_count,
             tokens_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni) begin
      if (in_if.valid && !in_if.ready) input_stall_cycles++;
      if (out_if.valid && out_if.ready) begin
        if (tokens_due.size() == 0) begin
          report_mismatch("token with none predicted, kind", out_if.token_kind, 0);
        end else begin
          want = tokens_due.pop_front();
          if (out_if.token_kind !== want.kind)
            report_mismatch("token_kind", out_if.token_kind, want.kind);
          if (out_if.error_code !== want.err)
            report_mismatch("error_code", out_if.error_code, want.err);
          if (out_if.line_number !== want.line)
            report_mismatch("line_number", out_if.line_number, want.line);
          if (out_if.start_column !== want.col)
            report_mismatch("start_column", out_if.start_column, want.col);
          if (out_if.token_length !== want.len)
            report_mismatch("token_length", out_if.token_length, want.len);
          if (out_if.last !== want.last)
            report_mismatch("last", out_if.last, want.last);
        end
        tokens_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------

  // offer one byte, wait for its transaction, then predict it
  task automatic send_byte(input logic [CH_W-1:0] c);
    while ($urandom_range(99) < source_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    scan_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // letter, underscore, or (not leading) digit
  function automatic logic [CH_W-1:0] pick_word_char(input bit leading);
    int unsigned r;
    r = $urandom_range(leading ? 52 : 62);
    if (r < 26) return CH_W'(CH_LO_A + r);
    if (r < 52) return CH_W'(CH_UP_A + r - 26);
    if (r == 52) return CH_USCORE;
    return CH_W'(CH_0 + r - 53);
  endfunction

  // one lexeme of random text, mostly well formed
  task automatic send_random_lexeme();
    int unsigned pick;
    int unsigned n;
    int unsigned dot_a;
    int unsigned dot_b;
    int unsigned dots;
    logic [CH_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // identifier
      n = $urandom_range(8);
      send_byte(pick_word_char(1'b1));
      repeat (n) send_byte(pick_word_char(1'b0));
    end else if (pick < 38) begin
      // number: mostly zero or one point, sometimes too many
      n     = $urandom_range(1, 7);
      dot_a = $urandom_range(n - 1);
      dot_b = $urandom_range(n - 1);
      dots  = $urandom_range(99);
      dots  = (dots < 45) ? 0 : (dots < 85) ? 1 : 2;
      for (int i = 0; i < n; i++) begin
        if ((dots >= 1 && i == dot_a) || (dots == 2 && i == dot_b)) send_byte(CH_DOT);
        else send_byte(CH_W'(CH_0 + $urandom_range(9)));
      end
    end else if (pick < 60) begin
      // operator, the four prefixes half the time in two-byte form
      n = $urandom_range(14);
      send_byte(OP_BYTES[n]);
      if (n >= 11 && $urandom_range(1)) send_byte(CH_EQ);
    end else if (pick < 72) begin
      // blanks
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(3))
          0: c = CH_SPACE;
          1: c = CH_TAB;
          2: c = CH_VT;
          default: c = CH_FEED;
        endcase
        send_byte(c);
      end
    end else if (pick < 77) begin
      send_byte(CH_LF);
    end else if (pick < 80) begin
      send_byte(CH_CR);
      send_byte(CH_LF);
    end else if (pick < 83) begin
      // carriage return sent without a line feed of its own
      send_byte(CH_CR);
    end else if (pick < 88) begin
      // comment body may hold anything short of line feed or end
      send_byte(CH_COLON);
      repeat ($urandom_range(6)) begin
        do c = CH_W'($urandom_range(1, 254)); while (c == CH_LF);
        send_byte(c);
        comment_bytes++;
      end
      send_byte(CH_LF);
    end else if (pick < 93) begin
      // byte that fits no token, lexed as an error token
      case ($urandom_range(3))
        0, 1: c = CH_W'($urandom_range(128, 254));
        2: c = odd_chars[$urandom_range(odd_chars.len() - 1)];
        default: begin
          n = $urandom_range(26);
          c = (n < 8) ? CH_W'(n + 1) : (n < 26) ? CH_W'(n + 6) : 8'h7F;
        end
      endcase
      send_byte(c);
    end else begin
      // noise, anything but the end markers
      send_byte(CH_W'($urandom_range(1, 254)));
    end
  endtask

  task automatic send_random_bytes(input int unsigned count);
    int unsigned start;
    start = bytes_sent - comment_bytes;
    while (bytes_sent - comment_bytes - start < count) send_random_lexeme();
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // every operator, one-byte forms closed by the next operator
  task automatic test_operators();
    send_text("=(!)<{>}+-/*^',==!=<=>=");
  endtask

  // identifier and number extremes, line endings, comment, odd bytes
  task automatic test_special_cases();
    send_text("_zA9 0.9 1..2");
    send_byte(CH_CR);
    send_text("+");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text(":");
    send_byte(CH_CR);
    send_text("#");
    send_byte(CH_LF);
    send_byte(CH_TAB);
    send_byte(CH_VT);
    send_byte(CH_FEED);
    send_byte(8'h80);
    send_byte(8'hFE);
    send_text("@.");
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_receiver_hold();
    hold_request = HOLD_CYCLES;
    send_random_bytes(40);
  endtask

  task automatic test_random_text();
    send_random_bytes(RANDOM_BYTES);
  endtask

  // both sides at full rate
  task automatic test_back_to_back();
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    send_random_bytes(BURST_BYTES);
    source_idle_pct = 28;
    sink_idle_pct   = 28;
  endtask

  // identifier and number lengths run into their top value
  task automatic test_saturation();
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    send_text("k");
    repeat (int'(LEN_MAX) + 4) send_byte(pick_word_char(1'b0));
    send_text(" 9");
    repeat (int'(LEN_MAX) + 4) send_byte(CH_W'(CH_0 + $urandom_range(9)));
    send_text(".5.");
    send_byte(CH_LF);
    send_text("n==");
    source_idle_pct = 28;
    sink_idle_pct   = 28;
  endtask

  // end of input with an identifier pending, then repeated eof tokens
  task automatic test_end_of_input();
    send_text("x1");
    send_byte(CH_NUL);
    send_byte(CH_FF_END);
    send_text("a=");
    send_byte(CH_LF);
    send_byte(CH_NUL);
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------

  initial begin
    int unsigned waited;
    mismatches         = 0;
    tokens_checked     = 0;
    bytes_sent         = 0;
    comment_bytes      = 0;
    input_stall_cycles = 0;
    hold_request       = 0;
    source_idle_pct    = 28;
    sink_idle_pct      = 28;
    reset_scanner();
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.ch    <= CH_NUL;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operators();
    test_special_cases();
    test_receiver_hold();
    test_random_text();
    test_back_to_back();
    test_saturation();
    test_end_of_input();
    in_if.valid <= 1'b0;

    // drain, then give stray tokens a chance to show up
    waited = 0;
    while (tokens_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tokens_due.size() != 0)
      report_mismatch("tokens never produced, count", tokens_due.size(), 0);

    $display("sent %0d source bytes (%0d inside comments), checked %0d tokens",
             bytes_sent, comment_bytes, tokens_checked);
    $display("%0d input stall cycles, %0d cycles, %0d mismatches", input_stall_cycles,
             cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("expression_language_lexer verification clean");
    end else begin
      $display("expression_language_lexer verification failed");
    end
    $finish;
  end

endmodule
